@@ rtl/grff_pkg.sv @@
package grff_pkg;

   // Field widths of the request and response words
   localparam int GRID_W   = 5;
   localparam int SIZE_W   = 5;
   localparam int COORD_W  = 4;
   localparam int TAG_W    = 16;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;

   // Scan arithmetic: a right edge (15 + 31) plus a width (31) stays below 128
   localparam int SCAN_W = 7;

   // Grid size after reset
   localparam logic [GRID_W-1:0] GRID_RESET = 5'd8;

   // Request kinds
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Register select, taken from address bit 2
   localparam logic CSR_GRID_COLUMNS = 1'b0;
   localparam logic CSR_GRID_ROWS    = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [SIZE_W-1:0]  item_width;
      logic [SIZE_W-1:0]  item_height;
      logic [TAG_W-1:0]   item_tag;
      logic [INDEX_W-1:0] remove_index;
   } grff_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  placed_col;
      logic [COORD_W-1:0]  placed_row;
      logic [INDEX_W-1:0]  entry_index;
      logic [TAG_W-1:0]    entry_tag;
      logic [COUNT_W-1:0]  entry_count;
   } grff_rsp_type;

   // One stored rectangle
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [TAG_W-1:0]   tag;
   } grff_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_CMP,
      ST_RM,
      ST_SHIFT,
      ST_DONE
   } grff_state_type;

endpackage

@@ rtl/grff_entry_ram.sv @@
module grff_entry_ram
   import grff_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  grff_entry_type      wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output grff_entry_type      rd_data
);

   grff_entry_type mem [DEPTH];
   grff_entry_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/grid_rectangle_first_fit_allocator.sv @@
// Add: a word that is rejected at once goes straight to the done step; otherwise the
//   sequencer scans candidate positions and tests each stored entry at each position.
//   One collision comparator reads one entry a cycle from the entry RAM.
// Remove: reads the entry, then one RAM copy per later entry; a bad index is rejected at once.
// One word at a time; the next word is taken while a finished response still waits.
// Synchronous reset empties the list and sets both grid sides to 8; entries hold no reset.
module grid_rectangle_first_fit_allocator
   import grff_pkg::*;
#(
   parameter int MAX_ENTRIES   = 32,
   parameter int MAX_GRID_SIDE = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  grff_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output grff_rsp_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam logic [SCAN_W-1:0] SIDE_MAX = SCAN_W'(MAX_GRID_SIDE);
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_ENTRIES);

   logic [GRID_W-1:0]  grid_columns_ff;
   logic [GRID_W-1:0]  grid_rows_ff;

   grff_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [SCAN_W-1:0]  col_ff, col_in;
   logic [SCAN_W-1:0]  row_ff, row_in;
   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   grff_rsp_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   grff_rsp_type       rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   grff_entry_type     wr_data;
   grff_entry_type     rd_data;
   logic [CNT_W-1:0]   shift_addr;
   logic [CNT_W-1:0]   idx_next;
   logic               place;

   logic [SCAN_W-1:0]  cols_ext, rows_ext, cols_lim, rows_lim;
   logic [SCAN_W-1:0]  c_end, r_end, ent_left, ent_top, ent_right, ent_bottom;
   logic               collide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_RESET;
         grid_rows_ff    <= GRID_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[2])
            CSR_GRID_COLUMNS: grid_columns_ff <= pwdata[GRID_W-1:0];
            CSR_GRID_ROWS:    grid_rows_ff    <= pwdata[GRID_W-1:0];
         endcase
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_GRID_ROWS) ? 32'(grid_rows_ff) : 32'(grid_columns_ff);

   // Saturate the grid sides
   assign cols_ext = SCAN_W'(grid_columns_ff);
   assign rows_ext = SCAN_W'(grid_rows_ff);
   assign cols_lim = (cols_ext > SIDE_MAX) ? SIDE_MAX : cols_ext;
   assign rows_lim = (rows_ext > SIDE_MAX) ? SIDE_MAX : rows_ext;

   // Shared overlap test of the candidate against one stored entry
   assign c_end      = col_ff + SCAN_W'(width_ff);
   assign r_end      = row_ff + SCAN_W'(height_ff);
   assign ent_left   = SCAN_W'(rd_data.left);
   assign ent_top    = SCAN_W'(rd_data.top);
   assign ent_right  = ent_left + SCAN_W'(rd_data.width);
   assign ent_bottom = ent_top + SCAN_W'(rd_data.height);
   assign collide    = (col_ff < ent_right) && (c_end > ent_left) &&
                       (row_ff < ent_bottom) && (r_end > ent_top);

   assign idx_next   = idx_ff + 1'b1;
   assign shift_addr = idx_ff - 1'b1;

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      tag_in       = tag_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = '{left: col_ff[COORD_W-1:0], top: row_ff[COORD_W-1:0],
                       width: width_ff, height: height_ff, tag: tag_ff};
      place        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               width_in  = req_data.item_width;
               height_in = req_data.item_height;
               tag_in    = req_data.item_tag;
               col_in    = '0;
               row_in    = '0;
               res_in    = '0;
               if (req_data.req_type == REQ_ADD) begin
                  if (count_ff >= CNT_MAX) begin
                     res_in.status = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else if (req_data.item_width == '0 || req_data.item_height == '0) begin
                     res_in.status = STATUS_NO_SPACE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_POS;
                  end
               end else begin
                  if (32'(req_data.remove_index) >= 32'(count_ff)) begin
                     res_in.status = STATUS_BAD_INDEX;
                     state_in      = ST_DONE;
                  end else begin
                     idx_in   = CNT_W'(req_data.remove_index);
                     state_in = ST_RM;
                  end
               end
            end
         end

         ST_POS: begin
            if (r_end > rows_lim) begin
               res_in.status = STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end else if (c_end > cols_lim) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else if (count_ff == '0) begin
               place = 1'b1;
            end else begin
               idx_in   = '0;
               state_in = ST_CMP;
            end
         end

         ST_CMP: begin
            if (collide) begin
               // every column up to this entry's right edge overlaps it
               col_in   = ent_right;
               state_in = ST_POS;
            end else if (idx_next == count_ff) begin
               place = 1'b1;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_RM: begin
            res_in.status      = STATUS_OK;
            res_in.placed_col  = rd_data.left;
            res_in.placed_row  = rd_data.top;
            res_in.entry_index = INDEX_W'(idx_ff);
            res_in.entry_tag   = rd_data.tag;
            idx_in             = idx_next;
            state_in           = ST_SHIFT;
         end

         ST_SHIFT: begin
            // move each later entry down by one
            if (idx_ff < count_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_addr[ADDR_W-1:0];
               wr_data = rd_data;
               idx_in  = idx_next;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = res_ff;
               rsp_data_in.entry_count  = COUNT_W'(count_ff);
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Append the rectangle at the end of the list
      if (place) begin
         wr_en              = 1'b1;
         res_in.status      = STATUS_OK;
         res_in.placed_col  = col_ff[COORD_W-1:0];
         res_in.placed_row  = row_ff[COORD_W-1:0];
         res_in.entry_index = INDEX_W'(count_ff);
         res_in.entry_tag   = tag_ff;
         count_in           = count_ff + 1'b1;
         state_in           = ST_DONE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      tag_ff      <= tag_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   grff_entry_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // The list never grows past its bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above bound");

   // An accepted word always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted word left the sequencer idle");

   // A new response only comes out of the done step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");

   // The count moves by one per request
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped");

   // The entry RAM is written only while placing or shifting
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_POS || state_ff == ST_CMP || state_ff == ST_SHIFT))
      else $error("entry write outside placement or shift");

endmodule
